// ===== rtl/core/pssc_pkg.sv =====
// Package for the packet sequence statistics counter.
// Holds the action codes, counter indexes, constants and the sequence check result type.
// No dependencies.
`default_nettype none

package pssc_pkg;

    typedef enum logic [2:0] {
        ACT_SENT     = 3'd0,
        ACT_POLL     = 3'd1,
        ACT_RECEIVED = 3'd2,
        ACT_DECFAIL  = 3'd3,
        ACT_SNAPSHOT = 3'd4,
        ACT_DRAIN    = 3'd5,
        ACT_CLEAR    = 3'd6
    } action_t;

    localparam int N_CUM  = 11;
    localparam int N_RATE = 4;

    // Cumulative counter indexes.
    localparam logic [3:0] C_MSG_TX   = 4'd0;
    localparam logic [3:0] C_BYTES_TX = 4'd1;
    localparam logic [3:0] C_MSG_RX   = 4'd2;
    localparam logic [3:0] C_BYTES_RX = 4'd3;
    localparam logic [3:0] C_POLLS    = 4'd4;
    localparam logic [3:0] C_HITS     = 4'd5;
    localparam logic [3:0] C_RAW      = 4'd6;
    localparam logic [3:0] C_GAPS     = 4'd7;
    localparam logic [3:0] C_OOO      = 4'd8;
    localparam logic [3:0] C_DUPS     = 4'd9;
    localparam logic [3:0] C_DECFAIL  = 4'd10;
    localparam logic [3:0] IDX_LASTSEQ = 4'd11;
    localparam logic [3:0] IDX_RATE0   = 4'd12;

    // Per-second counter indexes within the rate bank.
    localparam logic [1:0] R_TX      = 2'd0;
    localparam logic [1:0] R_TXBYTES = 2'd1;
    localparam logic [1:0] R_RX      = 2'd2;
    localparam logic [1:0] R_RXBYTES = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_REORDER_WINDOW  = 1'b0;
    localparam logic CFG_HEADER_OVERHEAD = 1'b1;

    localparam logic [31:0] REORDER_WINDOW_RESET  = 32'd1000;
    localparam logic [7:0]  HEADER_OVERHEAD_RESET = 8'd4;

    localparam logic [15:0] SEQ_MIN_LEN = 16'd8;
    localparam logic [63:0] WRAP_LIMIT  = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        dup;
        logic        ooo;
        logic        gap;
        logic [63:0] gap_amount;
        logic        advance;
    } seq_check_t;

endpackage

`default_nettype wire

// ===== rtl/core/packet_sequence_stats_counter.sv =====
// Top level of the packet sequence statistics counter.
// Depends on pssc_pkg and pssc_seq_check.
//
// Usage:
// Traffic events arrive as beats on the slave stream; s_tuser carries the action
// (sent, poll, received, decode failure, snapshot, drain, clear) and s_tdata the
// event fields. Every beat is first captured in an input register. Counter update
// events (sent, poll, received, decode failure, clear) are applied in the cycle
// after capture, so a new beat can be taken every cycle.
// Snapshot and drain produce result beats on the master stream: m_tuser is the
// counter index, m_tdata the zero-extended value, m_tlast marks the final beat.
// A snapshot holds the input register for 12 result beats (indexes 0..11), a drain for
// 4 beats (indexes 12..15); the rate is set by the single output register, which
// takes one result beat per cycle while the receiver accepts beats. The first result
// passes through the input register and then the output register.
// When the receiver stalls, the output register holds its beat, the emission
// sequencer waits, and s_tready drops once the input register is occupied.
// Reset clears all counters, the last sequence number and both streams, and loads
// the configuration registers with a window of 1000 and a header overhead of 4.
// The user must write the configuration port only while the block is idle; the block does not enforce it.
`default_nettype none

module packet_sequence_stats_counter
#(
    parameter int COUNTER_WIDTH = 32
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [31:0] message_count, [63:32] byte_count, [64] poll_hit,
    // [80:65] payload_length, [144:81] sequence_bytes, [151:145] zero
    input  wire logic [151:0] s_tdata,
    // [2:0] action
    input  wire logic [2:0]   s_tuser,

    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [63:0] counter_value
    output logic [63:0]       m_tdata,
    // [3:0] counter_index
    output logic [3:0]        m_tuser,
    // last_of_run
    output logic              m_tlast,

    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [31:0]  cfg_data
);

    localparam int CW = COUNTER_WIDTH;

    // Configuration registers.
    logic [31:0] window_reg;
    logic [7:0]  overhead_reg;

    // Input register.
    logic        in_valid_reg;
    logic [2:0]  in_action_reg;
    logic [31:0] in_msgs_reg;
    logic [31:0] in_bytes_reg;
    logic        in_hit_reg;
    logic [15:0] in_len_reg;
    logic [63:0] in_seq_reg;

    // Counter state.
    logic [CW-1:0] cum_reg  [pssc_pkg::N_CUM];
    logic [CW-1:0] cum_next [pssc_pkg::N_CUM];
    logic [CW-1:0] rate_reg  [pssc_pkg::N_RATE];
    logic [CW-1:0] rate_next [pssc_pkg::N_RATE];
    logic [63:0]   last_seq_reg;
    logic [63:0]   last_seq_next;

    // Emission sequencer and output register.
    logic [3:0]  beat_cnt_reg;
    logic [3:0]  beat_cnt_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [3:0]  out_index_reg;
    logic [63:0] out_value_reg;
    logic        out_last_reg;

    logic        is_snapshot;
    logic        is_emit;
    logic        emit_go;
    logic        last_beat;
    logic        consume;
    logic [3:0]  beat_index;
    logic [63:0] beat_value;
    logic        beat_last;

    // Event amounts at counter width.
    logic [63:0]   pkt_len64;
    logic [63:0]   msgs64;
    logic [63:0]   bytes64;
    logic [CW-1:0] pkt_len;
    logic [CW-1:0] msgs_amt;
    logic [CW-1:0] bytes_amt;
    logic [CW-1:0] one_cw;
    logic [CW-1:0] msg_rx_inc;

    pssc_pkg::seq_check_t chk;

    pssc_seq_check u_seq_check
    (
        .last_seq (last_seq_reg),
        .seq      (in_seq_reg),
        .window   (window_reg),
        .chk      (chk)
    );

    assign pkt_len64 = {48'd0, in_len_reg} + {56'd0, overhead_reg};
    assign msgs64    = {32'd0, in_msgs_reg};
    assign bytes64   = {32'd0, in_bytes_reg};
    assign pkt_len   = pkt_len64[CW-1:0];
    assign msgs_amt  = msgs64[CW-1:0];
    assign bytes_amt = bytes64[CW-1:0];
    assign one_cw    = {{(CW-1){1'b0}}, 1'b1};
    assign msg_rx_inc = cum_reg[pssc_pkg::C_MSG_RX] + one_cw;

    // Handshake and sequencing. Update events leave the input register at once;
    // snapshot and drain stay until their final beat enters the output register.
    assign is_snapshot = (in_action_reg == pssc_pkg::ACT_SNAPSHOT);
    assign is_emit     = is_snapshot || (in_action_reg == pssc_pkg::ACT_DRAIN);
    assign emit_go     = in_valid_reg && is_emit && (!out_valid_reg || m_tready);
    assign last_beat   = is_snapshot ? (beat_cnt_reg == pssc_pkg::IDX_LASTSEQ)
                                     : (beat_cnt_reg == 4'd3);
    assign consume     = in_valid_reg && (!is_emit || (emit_go && last_beat));
    assign s_tready    = !in_valid_reg || consume;

    always_comb
    begin
        if (is_snapshot)
        begin
            beat_index = beat_cnt_reg;
            beat_last  = last_beat;
            if (beat_cnt_reg == pssc_pkg::IDX_LASTSEQ)
            begin
                beat_value = last_seq_reg;
            end
            else if (beat_cnt_reg < pssc_pkg::IDX_LASTSEQ)
            begin
                beat_value = 64'(cum_reg[beat_cnt_reg]);
            end
            else
            begin
                beat_value = 64'd0;
            end
        end
        else
        begin
            beat_index = pssc_pkg::IDX_RATE0 + beat_cnt_reg;
            beat_last  = last_beat;
            beat_value = 64'(rate_reg[beat_cnt_reg[1:0]]);
        end
    end

    always_comb
    begin
        beat_cnt_next  = beat_cnt_reg;
        out_valid_next = out_valid_reg;
        if (emit_go)
        begin
            beat_cnt_next  = last_beat ? 4'd0 : beat_cnt_reg + 4'd1;
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Counter updates for the event in the input register.
    always_comb
    begin
        cum_next      = cum_reg;
        rate_next     = rate_reg;
        last_seq_next = last_seq_reg;
        if (consume)
        begin
            case (in_action_reg)
                pssc_pkg::ACT_SENT:
                begin
                    cum_next[pssc_pkg::C_MSG_TX]   = cum_reg[pssc_pkg::C_MSG_TX] + msgs_amt;
                    cum_next[pssc_pkg::C_BYTES_TX] = cum_reg[pssc_pkg::C_BYTES_TX] + bytes_amt;
                    rate_next[pssc_pkg::R_TX]      = rate_reg[pssc_pkg::R_TX] + msgs_amt;
                    rate_next[pssc_pkg::R_TXBYTES] = rate_reg[pssc_pkg::R_TXBYTES] + bytes_amt;
                end
                pssc_pkg::ACT_POLL:
                begin
                    cum_next[pssc_pkg::C_POLLS] = cum_reg[pssc_pkg::C_POLLS] + one_cw;
                    if (in_hit_reg)
                    begin
                        cum_next[pssc_pkg::C_HITS] = cum_reg[pssc_pkg::C_HITS] + one_cw;
                        cum_next[pssc_pkg::C_RAW]  = cum_reg[pssc_pkg::C_RAW] + bytes_amt;
                    end
                end
                pssc_pkg::ACT_RECEIVED:
                begin
                    cum_next[pssc_pkg::C_MSG_RX]   = msg_rx_inc;
                    cum_next[pssc_pkg::C_BYTES_RX] = cum_reg[pssc_pkg::C_BYTES_RX] + pkt_len;
                    rate_next[pssc_pkg::R_RX]      = rate_reg[pssc_pkg::R_RX] + one_cw;
                    rate_next[pssc_pkg::R_RXBYTES] = rate_reg[pssc_pkg::R_RXBYTES] + pkt_len;
                    if (in_len_reg >= pssc_pkg::SEQ_MIN_LEN)
                    begin
                        // The first packet, or the first after the receive count
                        // wraps back to one, only seeds the last sequence number.
                        if (msg_rx_inc == one_cw)
                        begin
                            last_seq_next = in_seq_reg;
                        end
                        else
                        begin
                            if (chk.dup)
                            begin
                                cum_next[pssc_pkg::C_DUPS] = cum_reg[pssc_pkg::C_DUPS] + one_cw;
                            end
                            else if (chk.ooo)
                            begin
                                cum_next[pssc_pkg::C_OOO] = cum_reg[pssc_pkg::C_OOO] + one_cw;
                            end
                            else if (chk.gap)
                            begin
                                cum_next[pssc_pkg::C_GAPS] = cum_reg[pssc_pkg::C_GAPS]
                                                             + chk.gap_amount[CW-1:0];
                            end
                            if (chk.advance)
                            begin
                                last_seq_next = in_seq_reg;
                            end
                        end
                    end
                end
                pssc_pkg::ACT_DECFAIL:
                begin
                    cum_next[pssc_pkg::C_DECFAIL] = cum_reg[pssc_pkg::C_DECFAIL] + one_cw;
                end
                pssc_pkg::ACT_DRAIN:
                begin
                    // The last drain beat has been loaded; the per-second bank restarts.
                    for (int i = 0; i < pssc_pkg::N_RATE; i++)
                    begin
                        rate_next[i] = '0;
                    end
                end
                pssc_pkg::ACT_CLEAR:
                begin
                    for (int i = 0; i < pssc_pkg::N_CUM; i++)
                    begin
                        cum_next[i] = '0;
                    end
                    for (int i = 0; i < pssc_pkg::N_RATE; i++)
                    begin
                        rate_next[i] = '0;
                    end
                    last_seq_next = 64'd0;
                end
                default:
                begin
                    // Snapshot changes nothing; the unused code is dropped.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= pssc_pkg::REORDER_WINDOW_RESET;
            overhead_reg  <= pssc_pkg::HEADER_OVERHEAD_RESET;
            in_valid_reg  <= 1'b0;
            beat_cnt_reg  <= 4'd0;
            out_valid_reg <= 1'b0;
            last_seq_reg  <= 64'd0;
            for (int i = 0; i < pssc_pkg::N_CUM; i++)
            begin
                cum_reg[i] <= '0;
            end
            for (int i = 0; i < pssc_pkg::N_RATE; i++)
            begin
                rate_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pssc_pkg::CFG_REORDER_WINDOW:  window_reg   <= cfg_data;
                    pssc_pkg::CFG_HEADER_OVERHEAD: overhead_reg <= cfg_data[7:0];
                    default:                       window_reg   <= window_reg;
                endcase
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            beat_cnt_reg  <= beat_cnt_next;
            out_valid_reg <= out_valid_next;
            cum_reg       <= cum_next;
            rate_reg      <= rate_next;
            last_seq_reg  <= last_seq_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_action_reg <= s_tuser;
            in_msgs_reg   <= s_tdata[31:0];
            in_bytes_reg  <= s_tdata[63:32];
            in_hit_reg    <= s_tdata[64];
            in_len_reg    <= s_tdata[80:65];
            in_seq_reg    <= s_tdata[144:81];
        end
        if (emit_go)
        begin
            out_index_reg <= beat_index;
            out_value_reg <= beat_value;
            out_last_reg  <= beat_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_index_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pssc_seq_check.sv =====
// Sequence number classifier for the packet sequence statistics counter.
// Pure combinational; depends on pssc_pkg for the result type and wrap limit.
`default_nettype none

module pssc_seq_check
(
    input  wire logic [63:0]         last_seq,
    input  wire logic [63:0]         seq,
    input  wire logic [31:0]         window,
    output pssc_pkg::seq_check_t     chk
);

    logic [63:0] expect_seq;
    logic [63:0] behind;
    logic        in_order;
    logic        is_dup;
    logic        is_ooo;

    assign expect_seq = last_seq + 64'd1;
    assign behind     = last_seq - seq;
    assign in_order   = (seq == expect_seq);
    assign is_dup     = !in_order && (seq == last_seq);
    // A zero window never matches, since behind is never below zero.
    assign is_ooo     = !in_order && !is_dup && (seq < last_seq)
                        && (behind < {32'd0, window});

    always_comb
    begin
        chk.dup        = is_dup;
        chk.ooo        = is_ooo;
        chk.gap        = !in_order && !is_dup && !is_ooo;
        chk.gap_amount = (seq > expect_seq) ? (seq - expect_seq) : 64'd1;
        chk.advance    = (seq > last_seq) || (behind > pssc_pkg::WRAP_LIMIT);
    end

endmodule

`default_nettype wire
